### rtl/ptm_pkg.sv
`timescale 1ns / 1ps

package ptm_pkg;

  // Sizes of the sorted store and of the fields.
  localparam int MaxN     = 16;
  localparam int TimeBits = 32;
  localparam int OutTimeW = 32;
  localparam int CountW   = 16;
  localparam int NselW    = 5;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 5;

  // Derived widths.
  localparam int IdxW  = $clog2(MaxN);
  localparam int KeepW = $clog2(MaxN + 1);
  localparam int SumW  = TimeBits + $clog2(MaxN);
  localparam int RemW  = KeepW + 1;
  localparam int StepW = $clog2(SumW);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MARK_MODE = 1'b0,
    REG_N_SELECT  = 1'b1
  } cfg_reg_e;

  // Time mark modes.
  typedef enum logic [ModeW-1:0] {
    MODE_FIRST = 2'd0,
    MODE_NTH   = 2'd1,
    MODE_MEAN  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e            mode;
    logic [NselW-1:0] n_select;
  } cfg_t;

  typedef struct packed {
    logic [31:0] photon_time;
    logic        photon_present;
    logic        event_end;
  } in_item_t;

  typedef struct packed {
    logic [OutTimeW-1:0] mark_time;
    logic                mark_valid;
    logic [CountW-1:0]   photon_total;
  } out_item_t;

  // One finished event, handed from the front to the back.
  typedef struct packed {
    logic              divide;
    logic              valid;
    logic [SumW-1:0]   dividend;
    logic [KeepW-1:0]  divisor;
    logic [CountW-1:0] total;
  } job_t;

endpackage

### rtl/ptm_front.sv
`timescale 1ns / 1ps

module ptm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptm_pkg::cfg_t       cfg_i,
  input  logic                item_push_i,
  output logic                item_full_o,
  input  ptm_pkg::in_item_t   item_i,
  output logic                job_push_o,
  input  logic                job_full_i,
  output ptm_pkg::job_t       job_o
);

  // Sorted times and running prefix sums, one pair per cell.
  logic [ptm_pkg::TimeBits-1:0] time_q [ptm_pkg::MaxN];
  logic [ptm_pkg::TimeBits-1:0] time_d [ptm_pkg::MaxN];
  logic [ptm_pkg::SumW-1:0]     psum_q [ptm_pkg::MaxN];
  logic [ptm_pkg::SumW-1:0]     psum_d [ptm_pkg::MaxN];
  logic [ptm_pkg::MaxN-1:0]     le;

  logic [ptm_pkg::KeepW-1:0]    kept_q, kept_d;
  logic [ptm_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic                         end_q, end_d;

  logic                         accept;
  logic                         take;
  logic [ptm_pkg::TimeBits-1:0] new_time;

  assign accept      = item_push_i && !end_q;
  assign take        = accept && item_i.photon_present;
  assign new_time    = ptm_pkg::TimeBits'(item_i.photon_time);
  assign item_full_o = end_q;
  assign job_push_o  = end_q && !job_full_i;

  // Each cell compares against the new time and either holds, takes the new
  // time, or takes its lower neighbor. Entries at or above the kept count are
  // never read, so their contents do not matter.
  for (genvar i = 0; i < ptm_pkg::MaxN; i++) begin : g_cell
    always_comb begin
      le[i] = (ptm_pkg::KeepW'(i) < kept_q) && (time_q[i] <= new_time);
    end

    if (i == 0) begin : g_first
      always_comb begin
        time_d[i] = le[i] ? time_q[i] : new_time;
        psum_d[i] = le[i] ? psum_q[i] : ptm_pkg::SumW'(new_time);
      end
    end else begin : g_rest
      always_comb begin
        if (le[i]) begin
          time_d[i] = time_q[i];
          psum_d[i] = psum_q[i];
        end else begin
          time_d[i] = le[i-1] ? new_time : time_q[i-1];
          psum_d[i] = psum_q[i-1] + ptm_pkg::SumW'(new_time);
        end
      end
    end
  end

  // Cell storage needs no reset; only entries below the kept count are used.
  always_ff @(posedge clk_i) begin
    if (take) begin
      time_q <= time_d;
      psum_q <= psum_d;
    end
  end

  // Event bookkeeping: kept count, photon count and the end-of-event flag.
  always_comb begin
    kept_d = kept_q;
    cnt_d  = cnt_q;
    end_d  = end_q;
    if (take) begin
      if (kept_q < ptm_pkg::KeepW'(ptm_pkg::MaxN)) begin
        kept_d = kept_q + 1'b1;
      end
      if (cnt_q != '1) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (accept && item_i.event_end) begin
      end_d = 1'b1;
    end
    if (job_push_o) begin
      kept_d = '0;
      cnt_d  = '0;
      end_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
      cnt_q  <= '0;
      end_q  <= 1'b0;
    end else begin
      kept_q <= kept_d;
      cnt_q  <= cnt_d;
      end_q  <= end_d;
    end
  end

  // Classify the finished event into a direct mark or a mean to divide.
  logic [ptm_pkg::KeepW-1:0] n_sat;
  logic [ptm_pkg::KeepW-1:0] mean_cnt;
  logic [ptm_pkg::KeepW-1:0] mean_m1;
  logic [ptm_pkg::NselW-1:0] n_m1;

  always_comb begin
    if (int'(cfg_i.n_select) > ptm_pkg::MaxN) begin
      n_sat = ptm_pkg::KeepW'(ptm_pkg::MaxN);
    end else begin
      n_sat = ptm_pkg::KeepW'(cfg_i.n_select);
    end
    mean_cnt = (kept_q < n_sat) ? kept_q : n_sat;
    mean_m1  = mean_cnt - 1'b1;
    n_m1     = cfg_i.n_select - 1'b1;

    job_o.divide   = 1'b0;
    job_o.valid    = 1'b0;
    job_o.dividend = '0;
    job_o.divisor  = mean_cnt;
    job_o.total    = cnt_q;

    unique case (cfg_i.mode)
      ptm_pkg::MODE_FIRST: begin
        if (kept_q != '0) begin
          job_o.valid    = 1'b1;
          job_o.dividend = ptm_pkg::SumW'(time_q[0]);
        end
      end
      ptm_pkg::MODE_NTH: begin
        if ((cfg_i.n_select != '0) && (int'(cfg_i.n_select) <= ptm_pkg::MaxN) &&
            (int'(kept_q) >= int'(cfg_i.n_select))) begin
          job_o.valid    = 1'b1;
          job_o.dividend = ptm_pkg::SumW'(time_q[n_m1[ptm_pkg::IdxW-1:0]]);
        end
      end
      ptm_pkg::MODE_MEAN: begin
        if (mean_cnt != '0) begin
          job_o.valid    = 1'b1;
          job_o.divide   = 1'b1;
          job_o.dividend = psum_q[mean_m1[ptm_pkg::IdxW-1:0]];
        end
      end
      default: begin
        job_o.valid = 1'b0;
      end
    endcase
  end

endmodule

### rtl/ptm_job_fifo.sv
`timescale 1ns / 1ps

module ptm_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptm_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output ptm_pkg::job_t rdata_o,
  output logic          empty_o
);

  // Two-entry queue between the front and the back.
  ptm_pkg::job_t slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    level_q;

  assign full_o  = level_q[1];
  assign empty_o = (level_q == 2'd0);
  assign rdata_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      level_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 2'd1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 2'd1;
      end
    end
  end

endmodule

### rtl/ptm_back.sv
`timescale 1ns / 1ps

module ptm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptm_pkg::job_t       job_i,
  input  logic                job_empty_i,
  output logic                job_pop_o,
  output ptm_pkg::out_item_t  res_o,
  output logic                res_empty_o,
  input  logic                res_pop_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [ptm_pkg::SumW-1:0]    quo_q, quo_d;
  logic [ptm_pkg::RemW-1:0]    rem_q, rem_d;
  logic [ptm_pkg::KeepW-1:0]   div_q;
  logic [ptm_pkg::StepW-1:0]   step_q, step_d;
  ptm_pkg::out_item_t          res_q;

  logic [ptm_pkg::RemW:0]      trial;
  logic [ptm_pkg::RemW:0]      divisor_ext;
  logic                        fits;

  assign job_pop_o   = (state_q == S_IDLE) && !job_empty_i;
  assign res_empty_o = (state_q != S_HOLD);
  assign res_o       = res_q;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial       = {rem_q, quo_q[ptm_pkg::SumW-1]};
    divisor_ext = (ptm_pkg::RemW + 1)'(div_q);
    fits        = (trial >= divisor_ext);
    rem_d       = fits ? ptm_pkg::RemW'(trial - divisor_ext) : ptm_pkg::RemW'(trial);
    quo_d       = {quo_q[ptm_pkg::SumW-2:0], fits};
    step_d      = step_q - 1'b1;
  end

  // Sequencer: take a job, divide if needed, hold the result until popped.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          state_d = job_i.divide ? S_DIV : S_HOLD;
        end
      end
      S_DIV: begin
        if (step_q == '0) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (res_pop_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      quo_q              <= job_i.dividend;
      rem_q              <= '0;
      div_q              <= job_i.divisor;
      step_q             <= ptm_pkg::StepW'(ptm_pkg::SumW - 1);
      res_q.mark_valid   <= job_i.valid;
      res_q.photon_total <= job_i.total;
      res_q.mark_time    <= job_i.valid ? ptm_pkg::OutTimeW'(job_i.dividend) : '0;
    end else if (state_q == S_DIV) begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      step_q <= step_d;
      if (step_q == '0) begin
        res_q.mark_time <= ptm_pkg::OutTimeW'(quo_d);
      end
    end
  end

endmodule

### rtl/photon_time_mark.sv
`timescale 1ns / 1ps
// Path: a direct mark passes the end flag, the job queue and the back-end result
// register; a mean mark also passes the 36-step quotient loop of the back-end divider.
// Throughput: one photon beat per cycle while full is low; an end beat stalls input until
// its event enters the job queue, and the back end takes a new event only after its last result is popped.
// Reset: asynchronous, active low; clears the event and queue state, sets mode
// to first photon and n to 1. No clearing pass is needed.

module photon_time_mark (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  ptm_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output ptm_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptm_pkg::CfgDataW-1:0]  cfg_data_i
);

  ptm_pkg::cfg_t cfg_q;
  ptm_pkg::job_t job_in, job_out;
  logic          job_push, job_full, job_pop, job_empty;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= ptm_pkg::MODE_FIRST;
      cfg_q.n_select <= ptm_pkg::NselW'(1);
    end else if (cfg_valid_i) begin
      unique case (ptm_pkg::cfg_reg_e'(cfg_index_i))
        ptm_pkg::REG_MARK_MODE: cfg_q.mode     <= ptm_pkg::mode_e'(cfg_data_i[ptm_pkg::ModeW-1:0]);
        ptm_pkg::REG_N_SELECT:  cfg_q.n_select <= cfg_data_i[ptm_pkg::NselW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  ptm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_push_i (push),
    .item_full_o (full),
    .item_i      (in_item_i),
    .job_push_o  (job_push),
    .job_full_i  (job_full),
    .job_o       (job_in)
  );

  ptm_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  ptm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (out_item_o),
    .res_empty_o (empty),
    .res_pop_i   (pop)
  );

`ifndef ASSERT_OFF
  // The front never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(job_push && job_full))
    else $error("job pushed into a full queue");

  // The back takes at most one job before it has delivered a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |=> !job_pop)
    else $error("back end took two jobs in a row");

  // A popped result frees the output, which shows empty before the next result appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pop && !empty) |=> empty)
    else $error("result shown right after a pop");

  // An invalid mark always carries a zero time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && !out_item_o.mark_valid) |-> (out_item_o.mark_time == '0))
    else $error("invalid mark with nonzero time");
`endif

endmodule
